>>> rtl/hcbd_pkg.sv
// Shared types, byte codes and helpers for the chunked body decoder.
`timescale 1ns / 1ps

package hcbd_pkg;

	localparam logic [7:0] CH_CR   = 8'd13;
	localparam logic [7:0] CH_LF   = 8'd10;
	localparam logic [7:0] CH_SEMI = 8'd59;

	typedef enum logic [3:0] {
		PH_SIZE    = 4'd0,
		PH_EXT     = 4'd1,
		PH_DATA    = 4'd2,
		PH_CRLF    = 4'd3,
		PH_TRAILER = 4'd4,
		PH_DONE    = 4'd5,
		PH_ERROR   = 4'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_BUSY  = 2'd0,
		ST_DONE  = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	// line tracking flags
	typedef struct packed {
		logic cr_seen;
		logic line_has_bytes;
	} line_flags_t;

	// one result transaction, laid out as on the output port
	typedef struct packed {
		status_t    status;
		logic       payload_valid;
		logic [7:0] data_byte;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.ok    = 1'b1;
		h.value = 4'd0;
		if (c >= 8'd48 && c <= 8'd57) begin
			h.value = 4'(c - 8'd48);
		end else if (c >= 8'd97 && c <= 8'd102) begin
			h.value = 4'(c - 8'd87);
		end else if (c >= 8'd65 && c <= 8'd70) begin
			h.value = 4'(c - 8'd55);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

>>> rtl/hcbd_step.sv
// Next-state and result logic for one body byte.
`timescale 1ns / 1ps

module hcbd_step #(
	parameter int SIZE_WIDTH = 32
) (
	input  logic [7:0]              in_byte,
	input  hcbd_pkg::phase_t        phase,
	input  logic [SIZE_WIDTH-1:0]   rem_len,
	input  hcbd_pkg::line_flags_t   flags,
	output hcbd_pkg::phase_t        phase_nxt,
	output logic [SIZE_WIDTH-1:0]   rem_len_nxt,
	output hcbd_pkg::line_flags_t   flags_nxt,
	output hcbd_pkg::result_t       result
);
	import hcbd_pkg::*;

	hex_t                  hex;
	logic                  size_ovf;
	logic [SIZE_WIDTH-1:0] rem_dec;

	assign hex      = hex_digit(in_byte);
	// any of the top nibble set: one more digit would overflow
	assign size_ovf = |rem_len[SIZE_WIDTH-1 -: 4];
	assign rem_dec  = rem_len - SIZE_WIDTH'(1);

	always_comb begin
		phase_nxt            = phase;
		rem_len_nxt          = rem_len;
		flags_nxt            = flags;
		result.data_byte     = 8'd0;
		result.payload_valid = 1'b0;
		case (phase)
			PH_SIZE: begin
				if (flags.cr_seen) begin
					if (in_byte == CH_LF) begin
						flags_nxt = '0;
						phase_nxt = (rem_len == '0) ? PH_TRAILER : PH_DATA;
					end else begin
						phase_nxt = PH_ERROR;
					end
				end else if (in_byte == CH_CR) begin
					flags_nxt.cr_seen = 1'b1;
				end else if (in_byte == CH_SEMI) begin
					phase_nxt = PH_EXT;
				end else if (!hex.ok || size_ovf) begin
					phase_nxt = PH_ERROR;
				end else begin
					rem_len_nxt = {rem_len[SIZE_WIDTH-5:0], hex.value};
				end
			end
			PH_EXT: begin
				if (in_byte == CH_CR) begin
					flags_nxt.cr_seen = 1'b1;
				end else if (in_byte == CH_LF && flags.cr_seen) begin
					flags_nxt = '0;
					phase_nxt = (rem_len == '0) ? PH_TRAILER : PH_DATA;
				end else begin
					flags_nxt.cr_seen = 1'b0;
				end
			end
			PH_DATA: begin
				result.data_byte     = in_byte;
				result.payload_valid = 1'b1;
				rem_len_nxt          = rem_dec;
				if (rem_dec == '0) begin
					phase_nxt         = PH_CRLF;
					flags_nxt.cr_seen = 1'b0;
				end
			end
			PH_CRLF: begin
				if (!flags.cr_seen) begin
					if (in_byte == CH_CR) flags_nxt.cr_seen = 1'b1;
					else phase_nxt = PH_ERROR;
				end else if (in_byte == CH_LF) begin
					flags_nxt.cr_seen = 1'b0;
					rem_len_nxt       = '0;
					phase_nxt         = PH_SIZE;
				end else begin
					phase_nxt = PH_ERROR;
				end
			end
			PH_TRAILER: begin
				if (in_byte == CH_CR) begin
					// CR CR: the first CR was line content
					if (flags.cr_seen) flags_nxt.line_has_bytes = 1'b1;
					flags_nxt.cr_seen = 1'b1;
				end else if (in_byte == CH_LF && flags.cr_seen) begin
					if (!flags.line_has_bytes) phase_nxt = PH_DONE;
					flags_nxt = '0;
				end else begin
					flags_nxt.line_has_bytes = 1'b1;
					flags_nxt.cr_seen        = 1'b0;
				end
			end
			PH_DONE: begin
			end
			default: begin
				phase_nxt = PH_ERROR;
			end
		endcase

		case (phase_nxt)
			PH_DONE:  result.status = ST_DONE;
			PH_ERROR: result.status = ST_ERROR;
			default:  result.status = ST_BUSY;
		endcase
	end

endmodule

>>> rtl/hcbd_out.sv
// Result register with a one-entry skid stage.
`timescale 1ns / 1ps

module hcbd_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hcbd_pkg::result_t push_data,
	output logic              ready,
	output logic              m_valid,
	input  logic              m_ready,
	output hcbd_pkg::result_t m_data
);
	import hcbd_pkg::*;

	logic    main_v_q;
	logic    skid_v_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;

	assign pop     = main_v_q && m_ready;
	assign ready   = !skid_v_q;
	assign m_valid = main_v_q;
	assign m_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) skid_v_q <= 1'b0;
		end else if (push) begin
			if (!main_v_q || pop) main_v_q <= 1'b1;
			else skid_v_q <= 1'b1;
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) main_q <= skid_q;
		end else if (push) begin
			if (!main_v_q || pop) main_q <= push_data;
			else skid_q <= push_data;
		end
	end

endmodule

>>> rtl/http_chunked_body_decoder.sv
// Top level of the HTTP chunked transfer-coding body decoder.
`timescale 1ns / 1ps

// Channel  Signals                      Payload
// s_*      s_tvalid s_tready s_tdata    in_byte [7:0]
// m_*      m_tvalid m_tready m_tdata    data_byte [7:0]
//          m_tuser                      payload_valid [0], status [2:1]
//
// One byte per cycle while s_tready is high: each accepted byte is decoded
// in the cycle it is taken and its result is registered at that edge, in the
// output register or, if that one is held, in the skid entry.
// The decoder state (phase, chunk length, CR/line flags) updates only on
// an accepted input transaction; the loop through that state sets the rate.
// arst_n clears the phase to the size line and the length and flags to zero.
// A stalled output fills the skid entry; s_tready drops only once both
// output entries hold results. Done and error stay until reset.

module http_chunked_body_decoder #(
	parameter int SIZE_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] data_byte
	output logic [2:0] m_tuser    // [0] payload_valid, [2:1] status
);
	import hcbd_pkg::*;

	phase_t                phase_q;
	logic [SIZE_WIDTH-1:0] rem_len_q;
	line_flags_t           flags_q;

	phase_t                phase_nxt;
	logic [SIZE_WIDTH-1:0] rem_len_nxt;
	line_flags_t           flags_nxt;
	result_t               step_res;
	result_t               out_res;
	logic                  accept;

	assign accept = s_tvalid && s_tready;

	hcbd_step #(
		.SIZE_WIDTH (SIZE_WIDTH)
	) u_step (
		.in_byte     (s_tdata),
		.phase       (phase_q),
		.rem_len     (rem_len_q),
		.flags       (flags_q),
		.phase_nxt   (phase_nxt),
		.rem_len_nxt (rem_len_nxt),
		.flags_nxt   (flags_nxt),
		.result      (step_res)
	);

	// decoder state advances once per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SIZE;
			rem_len_q <= '0;
			flags_q   <= '0;
		end else if (accept) begin
			phase_q   <= phase_nxt;
			rem_len_q <= rem_len_nxt;
			flags_q   <= flags_nxt;
		end
	end

	hcbd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (step_res),
		.ready     (s_tready),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_data    (out_res)
	);

	assign m_tdata = out_res.data_byte;
	assign m_tuser = {out_res.status, out_res.payload_valid};

endmodule

>>> test/http_chunked_body_decoder_checker.sv
// Result predictor and scoreboard for the chunked body decoder channels.
`timescale 1ns / 1ps

module http_chunked_body_decoder_checker #(
	parameter int SIZE_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] data_byte
	input  logic [2:0] m_tuser,   // [0] payload_valid, [2:1] status
	output int         errors,
	output int         outstanding,
	output int         results_checked,
	output int         payload_count
);
	import hcbd_pkg::*;

	// a further digit is refused once the size is above this
	localparam logic [SIZE_WIDTH-1:0] SIZE_LIMIT = {SIZE_WIDTH{1'b1}} >> 4;

	phase_t                dec_phase;
	logic [SIZE_WIDTH-1:0] chunk_left;
	logic                  cr_pending;
	logic                  line_busy;
	result_t               due_results[$];

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= 8'd48 && c <= 8'd57) return int'(c) - 48;
		if (c >= 8'd97 && c <= 8'd102) return int'(c) - 87;
		if (c >= 8'd65 && c <= 8'd70) return int'(c) - 55;
		return -1;
	endfunction

	function automatic void end_size_line();
		cr_pending = 1'b0;
		line_busy  = 1'b0;
		dec_phase  = (chunk_left == '0) ? PH_TRAILER : PH_DATA;
	endfunction

	// advances the decoder state by one byte and returns its result
	function automatic result_t decode_byte(input logic [7:0] c);
		result_t r;
		int      nib;
		r.data_byte     = 8'd0;
		r.payload_valid = 1'b0;
		r.status        = ST_BUSY;
		nib = nibble_of(c);
		case (dec_phase)
			PH_SIZE: begin
				if (cr_pending) begin
					if (c == CH_LF) end_size_line();
					else dec_phase = PH_ERROR;
				end else if (c == CH_CR) begin
					cr_pending = 1'b1;
				end else if (c == CH_SEMI) begin
					dec_phase = PH_EXT;
				end else if (nib < 0 || chunk_left > SIZE_LIMIT) begin
					dec_phase = PH_ERROR;
				end else begin
					chunk_left = {chunk_left[SIZE_WIDTH-5:0], 4'(nib)};
				end
			end
			PH_EXT: begin
				if (c == CH_CR) cr_pending = 1'b1;
				else if (c == CH_LF && cr_pending) end_size_line();
				else cr_pending = 1'b0;
			end
			PH_DATA: begin
				r.data_byte     = c;
				r.payload_valid = 1'b1;
				chunk_left      = chunk_left - 1'b1;
				if (chunk_left == '0) begin
					dec_phase  = PH_CRLF;
					cr_pending = 1'b0;
				end
			end
			PH_CRLF: begin
				if (!cr_pending) begin
					if (c == CH_CR) cr_pending = 1'b1;
					else dec_phase = PH_ERROR;
				end else if (c == CH_LF) begin
					cr_pending = 1'b0;
					chunk_left = '0;
					dec_phase  = PH_SIZE;
				end else begin
					dec_phase = PH_ERROR;
				end
			end
			PH_TRAILER: begin
				if (c == CH_CR) begin
					if (cr_pending) line_busy = 1'b1;
					cr_pending = 1'b1;
				end else if (c == CH_LF && cr_pending) begin
					if (!line_busy) dec_phase = PH_DONE;
					cr_pending = 1'b0;
					line_busy  = 1'b0;
				end else begin
					line_busy  = 1'b1;
					cr_pending = 1'b0;
				end
			end
			PH_DONE: ;
			default: dec_phase = PH_ERROR;
		endcase
		if (dec_phase == PH_DONE) r.status = ST_DONE;
		else if (dec_phase == PH_ERROR) r.status = ST_ERROR;
		return r;
	endfunction

	// output side is checked before the input of the same edge is predicted
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			dec_phase       = PH_SIZE;
			chunk_left      = '0;
			cr_pending      = 1'b0;
			line_busy       = 1'b0;
			due_results.delete();
			errors          = 0;
			outstanding     = 0;
			results_checked = 0;
			payload_count   = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tuser[2:1], m_tuser[0], m_tdata};
				results_checked++;
				if (got.payload_valid) payload_count++;
				if (due_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("result %0d with nothing expected: data %02h valid %0b status %0d",
							results_checked, got.data_byte, got.payload_valid, got.status);
				end else begin
					want = due_results.pop_front();
					if (got.data_byte !== want.data_byte ||
							got.payload_valid !== want.payload_valid ||
							got.status !== want.status) begin
						errors++;
						if (errors <= 10)
							$display({"result %0d mismatch: expected data %02h valid %0b status %0d,",
								" got data %02h valid %0b status %0d"}, results_checked,
								want.data_byte, want.payload_valid, want.status,
								got.data_byte, got.payload_valid, got.status);
					end
				end
			end
			if (s_tvalid && s_tready) due_results.push_back(decode_byte(s_tdata));
			outstanding = due_results.size();
		end
	end

endmodule

>>> test/http_chunked_body_decoder_test.sv
// Stimulus and verdict for the chunked body decoder.
`timescale 1ns / 1ps

// Builds one chunked body (the decoder is reset once, and done and error
// are sticky, so the run is one long body): a short hand-made chunk, then
// random chunks, then one randomly chosen ending, either a trailer section
// that completes the body or one kind of protocol error, followed by bytes
// that must all report the sticky status. Both channels idle in random
// bursts; once the receiver holds off long enough to fill the decoder.

module http_chunked_body_decoder_test;
	import hcbd_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int BODY_TARGET = 1850;    // random chunks stop past this size
	localparam int QUIET_TAIL  = 150;     // last transactions with no idling
	localparam int HOLD_AT     = 300;     // bytes sent before the long hold
	localparam int HOLD_CYCLES = 200;
	localparam int TAIL_BYTES  = 40;      // bytes after the final status
	localparam int CYCLE_LIMIT = 500000;

	typedef enum {END_DONE, END_BAD_CHAR, END_OVERFLOW, END_BAD_TERM} ending_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] in_byte
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [7:0] data_byte
	logic [2:0] m_tuser;   // [0] payload_valid, [2:1] status

	int         errors;
	int         outstanding;
	int         results_checked;
	int         payload_count;
	int         cycles;
	int         bytes_sent;
	int         chunk_total;
	bit         quiet;
	ending_t    ending;
	logic [7:0] body[$];

	http_chunked_body_decoder #(
		.SIZE_WIDTH(32)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	http_chunked_body_decoder_checker #(
		.SIZE_WIDTH(32)
	) u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.errors         (errors),
		.outstanding    (outstanding),
		.results_checked(results_checked),
		.payload_count  (payload_count)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// hex digit with random letter case
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return 8'd48 + nib;
		return ($urandom_range(0, 1) ? 8'd65 : 8'd97) + nib - 8'd10;
	endfunction

	task automatic add_crlf();
		body.push_back(CH_CR);
		body.push_back(CH_LF);
	endtask

	// line content rich in CR and LF, never a CR directly followed by LF
	task automatic add_line_content(input int count);
		logic [7:0] b;
		logic [7:0] prev;
		prev = 8'd0;
		repeat (count) begin
			case ($urandom_range(0, 7))
				0, 1:    b = CH_CR;
				2:       b = CH_LF;
				default: b = 8'($urandom_range(0, 255));
			endcase
			if (prev == CH_CR && b == CH_LF) b = 8'h20;
			body.push_back(b);
			prev = b;
		end
	endtask

	// size line: optional leading zeros, hex digits, optional extension, CRLF
	task automatic add_size_line(input logic [31:0] value, input bit with_ext);
		int zeros;
		int digits;
		zeros  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 1);
		digits = 1;
		repeat (zeros) body.push_back(hex_char(4'd0));
		while (digits < 8 && (value >> (4 * digits)) != 0) digits++;
		for (int k = digits - 1; k >= 0; k--) body.push_back(hex_char(value[4 * k +: 4]));
		if (with_ext) begin
			body.push_back(CH_SEMI);
			add_line_content($urandom_range(0, 6));
		end
		add_crlf();
	endtask

	task automatic add_chunk_data(input int count);
		repeat (count) body.push_back(8'($urandom_range(0, 255)));
	endtask

	// receiver: random stall bursts, one long hold, none near the end
	initial begin
		bit held;
		held     = 1'b0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (!held && bytes_sent >= HOLD_AT) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (!quiet && (cycles / 200) % 3 != 1 && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(negedge clk);
		end
	end

	initial begin
		int         sz;
		logic [7:0] b;
		s_tvalid    = 1'b0;
		s_tdata     = 8'd0;
		quiet       = 1'b0;
		bytes_sent  = 0;
		chunk_total = 1;

		// size "00a" with an extension holding a lone CR, then ten data bytes
		// at the extremes and the control characters, then CRLF
		body = '{8'd48, 8'd48, 8'd97, CH_SEMI, 8'd120, CH_CR, 8'd121, CH_CR, CH_LF,
			8'h00, 8'hFF, CH_CR, CH_LF, CH_SEMI, 8'd102, 8'h55, 8'hAA, 8'h80, 8'h01,
			CH_CR, CH_LF};

		// well-formed chunks, mostly short
		while (body.size() < BODY_TARGET) begin
			sz = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
			add_size_line(sz, $urandom_range(0, 3) == 0);
			add_chunk_data(sz);
			add_crlf();
			chunk_total++;
		end

		case ($urandom_range(0, 5))
			0:       ending = END_BAD_CHAR;
			1:       ending = END_OVERFLOW;
			2:       ending = END_BAD_TERM;
			default: ending = END_DONE;
		endcase

		case (ending)
			END_DONE: begin
				// last chunk as "0" or as a size line with no digits
				if ($urandom_range(0, 1)) begin
					add_size_line(0, 1'($urandom_range(0, 1)));
				end else begin
					if ($urandom_range(0, 1)) begin
						body.push_back(CH_SEMI);
						add_line_content($urandom_range(0, 6));
					end
					add_crlf();
				end
				repeat ($urandom_range(0, 3)) begin
					add_line_content($urandom_range(1, 10));
					add_crlf();
				end
				add_crlf();
			end
			END_BAD_CHAR: begin
				repeat ($urandom_range(0, 3)) body.push_back(hex_char(4'($urandom_range(0, 15))));
				case ($urandom_range(0, 2))
					0: begin
						// CR not followed by LF
						body.push_back(CH_CR);
						do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
						body.push_back(b);
					end
					1: body.push_back(CH_LF);
					default: begin
						do b = 8'($urandom_range(0, 255));
						while ((b >= 8'd48 && b <= 8'd57) || (b >= 8'd65 && b <= 8'd70) ||
							(b >= 8'd97 && b <= 8'd102) || b == CH_SEMI || b == CH_CR);
						body.push_back(b);
					end
				endcase
			end
			END_OVERFLOW: begin
				// nine significant digits: the ninth cannot fit
				body.push_back(hex_char(4'($urandom_range(1, 15))));
				repeat (8) body.push_back(hex_char(4'($urandom_range(0, 15))));
			end
			END_BAD_TERM: begin
				sz = $urandom_range(1, 8);
				add_size_line(sz, 1'b0);
				add_chunk_data(sz);
				if ($urandom_range(0, 1)) begin
					do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
					body.push_back(b);
				end else begin
					body.push_back(CH_CR);
					do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
					body.push_back(b);
				end
			end
		endcase

		// everything after the final status must repeat it
		add_chunk_data(TAIL_BYTES);

		wait (arst_n === 1'b1);
		@(negedge clk);
		foreach (body[i]) begin
			if (i >= body.size() - QUIET_TAIL) quiet = 1'b1;
			if (!quiet && (i / 128) % 3 != 2 && $urandom_range(0, 9) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= body[i];
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			bytes_sent++;
			@(negedge clk);
		end
		s_tvalid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("Decoded %0d body bytes in %0d chunks; %0d of %0d results carried payload.",
			body.size(), chunk_total, payload_count, results_checked);
		$display("Body ended with %s, then %0d bytes checked against the held status.",
			ending.name(), TAIL_BYTES);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
